// ===== rtl/core/lspp_pkg.sv =====
package lspp_pkg;

  localparam int unsigned CH_PER_ROW = 8;
  localparam int unsigned NUM_BANKS  = 4;

  localparam logic [7:0] STATE_MARK   = 8'd64;
  localparam logic [7:0] MODE_CONST_MAX = 8'd49;
  localparam logic [7:0] MODE_TRIANGLE = 8'd129;
  localparam logic [7:0] MODE_SQUARE   = 8'd130;
  localparam logic [7:0] MODE_FALLING  = 8'd131;
  localparam logic [7:0] MODE_RISING   = 8'd132;

  localparam logic [5:0] DUTY_MAX      = 6'd49;
  localparam logic [5:0] PERIOD_RELOAD = 6'd48;
  localparam logic [9:0] STEP_RESET    = 10'd256;
  localparam logic [7:0] SPEED_MAX     = 8'd7;

  localparam logic [1:0] REG_INVERT = 2'd0;

  // precomputed waveform duties for the current phase
  typedef struct packed {
    logic [5:0] tri_d;
    logic [5:0] sq_d;
    logic [5:0] fall_d;
    logic [5:0] rise_d;
  } wave_t;

  function automatic logic [5:0] duty_sel(input logic [7:0] mode, input wave_t w);
    logic [5:0] d;
    d = '0;
    priority if (mode <= MODE_CONST_MAX) d = mode[5:0];
    else if (mode == MODE_TRIANGLE)      d = w.tri_d;
    else if (mode == MODE_SQUARE)        d = w.sq_d;
    else if (mode == MODE_FALLING)       d = w.fall_d;
    else if (mode == MODE_RISING)        d = w.rise_d;
    else                                 d = '0;
    return d;
  endfunction

endpackage

// ===== rtl/core/led_soft_pwm_profiles_top.sv =====
// channel  direction  handshake          payload
// in       sink       in_valid/in_stall  in_func, in_byte_0..in_byte_7
// out      source     out_valid/out_stall out_pin_levels
// cfg      apb slave  cfg_psel/penable   invert_mask at byte address 0
//
// packets are handled in S_IDLE; a tick goes to S_PINS, or first through S_WAVE
// and S_ROW, one mode memory row (eight channels) per cycle, on a counter wrap.
// synchronous active-low reset; mode rows carry valid bits, so no clearing pass.
// in_stall is high while a tick is in flight; a finished beat waits in the
// output register and holds the tick back only if out_stall still blocks it.
module led_soft_pwm_profiles_top #(
  parameter int NUM_CHANNELS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [7:0]  in_byte_0,
  input  logic [7:0]  in_byte_1,
  input  logic [7:0]  in_byte_2,
  input  logic [7:0]  in_byte_3,
  input  logic [7:0]  in_byte_4,
  input  logic [7:0]  in_byte_5,
  input  logic [7:0]  in_byte_6,
  input  logic [7:0]  in_byte_7,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_pin_levels,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import lspp_pkg::*;

  localparam int ROWS = (NUM_CHANNELS + 7) / 8;
  localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [RAW-1:0] LAST_ROW = RAW'(ROWS - 1);
  localparam logic [31:0] CH_MASK = 32'((64'd1 << NUM_CHANNELS) - 64'd1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WAVE = 4'b0010,
    S_ROW  = 4'b0100,
    S_PINS = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [31:0]             invert_r;
  logic [NUM_CHANNELS-1:0] enable_r;
  logic [5:0]              cnt_r;
  logic [15:0]             phase_r;
  logic [9:0]              step_r;
  logic [1:0]              bank_r;
  logic [RAW-1:0]          row_r;
  logic [ROWS-1:0]         row_vld_r;
  logic                    out_valid_r;
  logic [31:0]             out_pins_r;

  logic [63:0]             mode_mem [ROWS];
  logic [63:0]             rd_data_r;
  logic                    rd_vld_r;
  logic [RAW-1:0]          rd_addr;
  logic [63:0]             mode_row;

  logic                    in_acc;
  logic                    pkt_acc;
  logic                    tick_acc;
  logic                    is_state_pkt;
  logic                    bank_exists;
  logic [63:0]             pkt_row;
  logic [31:0]             pkt_en;
  logic [7:0]              speed;
  logic                    out_free;
  logic                    cfg_wr;
  logic [NUM_CHANNELS-1:0] pins_w;
  logic [31:0]             pins_out;
  wave_t                   wave;

  assign in_stall     = (state_r != S_IDLE);
  assign in_acc       = in_valid && !in_stall;
  assign pkt_acc      = in_acc && !in_func;
  assign tick_acc     = in_acc && in_func;
  assign is_state_pkt = (in_byte_0 == STATE_MARK);
  assign bank_exists  = (3'(bank_r) < 3'(ROWS));
  assign pkt_row      = {in_byte_7, in_byte_6, in_byte_5, in_byte_4,
                         in_byte_3, in_byte_2, in_byte_1, in_byte_0};
  assign pkt_en       = {in_byte_4, in_byte_3, in_byte_2, in_byte_1};
  assign out_free     = !out_valid_r || !out_stall;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_pready   = 1'b1;
  assign cfg_prdata   = (cfg_paddr == REG_INVERT) ? invert_r : 32'd0;
  assign out_valid      = out_valid_r;
  assign out_pin_levels = out_pins_r;

  always_comb begin
    if (in_byte_5 > SPEED_MAX) speed = SPEED_MAX;
    else if (in_byte_5 == 8'd0) speed = 8'd1;
    else speed = in_byte_5;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (tick_acc) state_nxt = (cnt_r == 6'd0) ? S_WAVE : S_PINS;
      end
      S_WAVE: state_nxt = S_ROW;
      S_ROW: begin
        if (row_r == LAST_ROW) state_nxt = S_PINS;
      end
      S_PINS: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      invert_r    <= '0;
      enable_r    <= '0;
      cnt_r       <= '0;
      phase_r     <= '0;
      step_r      <= STEP_RESET;
      bank_r      <= '0;
      row_r       <= '0;
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr && cfg_paddr == REG_INVERT) invert_r <= cfg_pwdata;
      if (pkt_acc) begin
        if (is_state_pkt) begin
          enable_r <= pkt_en[NUM_CHANNELS-1:0];
          step_r   <= {speed[2:0], 7'd0};
          bank_r   <= '0;
        end else begin
          if (bank_exists) row_vld_r[bank_r[RAW-1:0]] <= 1'b1;
          bank_r <= bank_r + 2'd1;
        end
      end
      if (tick_acc) begin
        if (cnt_r == 6'd0) begin
          cnt_r   <= PERIOD_RELOAD;
          phase_r <= phase_r + {6'd0, step_r};
        end else begin
          cnt_r <= cnt_r - 6'd1;
        end
      end
      if (state_r == S_WAVE) row_r <= '0;
      else if (state_r == S_ROW) row_r <= row_r + RAW'(1);
      if (state_r == S_PINS && out_free) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // mode memory: one row per bank of eight channels
  assign rd_addr = (state_r == S_ROW && row_r != LAST_ROW) ? row_r + RAW'(1) : '0;

  always_ff @(posedge clk) begin
    if (pkt_acc && !is_state_pkt && bank_exists) mode_mem[bank_r[RAW-1:0]] <= pkt_row;
    rd_data_r <= mode_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= row_vld_r[rd_addr];
  end

  // never written rows read as mode zero
  assign mode_row = rd_vld_r ? rd_data_r : 64'd0;

  lspp_wave u_wave (
    .clk    (clk),
    .phase  (phase_r),
    .wave_r (wave)
  );

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    localparam int ROW  = c / 8;
    localparam int LANE = c % 8;
    logic [5:0] duty_r;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        duty_r <= '0;
      end else if (state_r == S_ROW && row_r == RAW'(ROW)) begin
        duty_r <= enable_r[c] ? duty_sel(mode_row[LANE*8 +: 8], wave) : 6'd0;
      end
    end

    assign pins_w[c] = (duty_r > cnt_r);
  end

  assign pins_out = (32'(pins_w) ^ invert_r) & CH_MASK;

  always_ff @(posedge clk) begin
    if (state_r == S_PINS && out_free) out_pins_r <= pins_out;
  end

endmodule

// ===== rtl/core/lspp_wave.sv =====
module lspp_wave (
  input  logic                clk,
  input  logic [15:0]         phase,
  output lspp_pkg::wave_t     wave_r
);
  import lspp_pkg::*;

  logic [7:0]  p;
  logic [7:0]  q;
  logic [13:0] tri_prod;
  logic [13:0] fall_prod;
  logic [13:0] rise_prod;
  wave_t       wave_nxt;

  // times 49 as shift and add
  function automatic logic [13:0] mul49(input logic [7:0] x);
    return {1'b0, x, 5'b0} + {2'b0, x, 4'b0} + {6'b0, x};
  endfunction

  always_comb begin
    p         = phase[15:8];
    q         = p[7] ? ~p : p;
    tri_prod  = mul49(q);
    fall_prod = mul49(~p);
    rise_prod = mul49(p);
    wave_nxt.tri_d  = tri_prod[12:7];
    wave_nxt.sq_d   = phase[15] ? DUTY_MAX : 6'd0;
    wave_nxt.fall_d = fall_prod[13:8];
    wave_nxt.rise_d = rise_prod[13:8];
  end

  always_ff @(posedge clk) begin
    wave_r <= wave_nxt;
  end

endmodule

// ===== rtl/core/lspp_checker.sv =====
module lspp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        in_func,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_pin_levels
);

  // a held beat stays valid
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pin_levels))
    else $error("out payload changed while stalled");

  // a tick always leaves the block busy in the cycle after it is taken
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_func |=> in_stall)
    else $error("tick did not hold the input");

  // packets never produce a result beat
  a_pkt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_func |=> !$rose(out_valid))
    else $error("packet produced a beat");

endmodule

bind led_soft_pwm_profiles_top lspp_checker u_lspp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_func        (in_func),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_pin_levels (out_pin_levels)
);
